// ----- rtl/core/arc_pkg.sv -----
// Shared types and constants for the advertising reconcile controller.
// Used by the front end, the op queue, the back end and the top level.
// Depends on nothing.
package arc_pkg;

  // Size of the manufacturer payload, in bytes (1 to 31).
  localparam int PAYLOAD_BYTES = 24;
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

  // Event modes on the input channel.
  localparam logic [3:0] MODE_BYTE        = 4'd0;
  localparam logic [3:0] MODE_WANT_START  = 4'd1;
  localparam logic [3:0] MODE_WANT_STOP   = 4'd2;
  localparam logic [3:0] MODE_STACK_READY = 4'd3;
  localparam logic [3:0] MODE_STACK_RESET = 4'd4;
  localparam logic [3:0] MODE_LINKS       = 4'd5;
  localparam logic [3:0] MODE_ENDED       = 4'd6;
  localparam logic [3:0] MODE_PROCESS     = 4'd7;
  localparam logic [3:0] MODE_RESULT      = 4'd8;

  // Commands issued to the radio stack.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_PROG  = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  // Outcomes reported with a result item.
  localparam logic [2:0] OC_NONE       = 3'd0;
  localparam logic [2:0] OC_RECONCILED = 3'd1;
  localparam logic [2:0] OC_ACTED      = 3'd2;
  localparam logic [2:0] OC_BUSY       = 3'd3;
  localparam logic [2:0] OC_FAULTED    = 3'd4;

  // Stack reply codes.
  localparam logic [2:0] CODE_NOT_ACTIVE = 3'd2;
  localparam logic [2:0] CODE_RETRY      = 3'd3;

  // Operations after classification by the front end.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_BYTE,
    OP_COMMIT,
    OP_WANT_ON,
    OP_WANT_OFF,
    OP_READY,
    OP_RESET,
    OP_LINKS,
    OP_ENDED,
    OP_PROCESS,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [7:0]       links;
    logic             permit;
    logic [2:0]       code;
  } entry_t;

  // Write side of the op queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  // Read side of the op queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

endpackage

// ----- rtl/core/arc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the staged and the held payload. Depends on nothing.
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/arc_queue.sv -----
// Two-entry queue of classified operations between the front and back ends.
// Depends on arc_pkg.
module arc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  arc_pkg::q_wr_t q_wr,
  input  logic           q_pop,
  output arc_pkg::q_rd_t q_rd,
  output logic           q_full
);
  import arc_pkg::*;

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;

  assign q_full  = (count_r == 2'd2);
  assign do_push = q_wr.push && !q_full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (do_push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  assign q_rd.valid = (count_r != 2'd0);
  assign q_rd.entry = slot_r[rd_ptr_r];

endmodule

// ----- rtl/core/arc_front.sv -----
// Front end: accepts input items and classifies each into one queued operation.
// Depends on arc_pkg.
module arc_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [3:0]     in_mode,
  input  logic [7:0]     in_payload_byte,
  input  logic [4:0]     in_byte_index,
  input  logic [7:0]     in_link_count,
  input  logic           in_start_permit,
  input  logic [2:0]     in_stack_code,
  input  logic           q_full,
  output arc_pkg::q_wr_t q_wr
);
  import arc_pkg::*;

  localparam logic [4:0] IDX_LIMIT = 5'(PAYLOAD_BYTES);
  localparam logic [4:0] IDX_LAST  = 5'(PAYLOAD_BYTES - 1);

  op_t op;

  always_comb begin
    unique case (in_mode)
      MODE_BYTE: begin
        if (in_byte_index >= IDX_LIMIT) begin
          op = OP_NOP;
        end else if (in_byte_index == IDX_LAST) begin
          op = OP_COMMIT;
        end else begin
          op = OP_BYTE;
        end
      end
      MODE_WANT_START:  op = OP_WANT_ON;
      MODE_WANT_STOP:   op = OP_WANT_OFF;
      MODE_STACK_READY: op = OP_READY;
      MODE_STACK_RESET: op = OP_RESET;
      MODE_LINKS:       op = OP_LINKS;
      MODE_ENDED:       op = OP_ENDED;
      MODE_PROCESS:     op = OP_PROCESS;
      MODE_RESULT:      op = OP_RESULT;
      default:          op = OP_NOP;
    endcase
  end

  assign in_stall          = q_full;
  assign q_wr.push         = in_valid && !q_full;
  assign q_wr.entry.op     = op;
  assign q_wr.entry.data   = in_payload_byte;
  assign q_wr.entry.idx    = in_byte_index[IDX_W-1:0];
  assign q_wr.entry.links  = in_link_count;
  assign q_wr.entry.permit = in_start_permit;
  assign q_wr.entry.code   = in_stack_code;

endmodule

// ----- rtl/core/arc_back.sv -----
// Back end: holds the reconcile state and both payload RAMs, carries out queued
// operations and drives the result register. Depends on arc_pkg and arc_ram.
module arc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  arc_pkg::q_rd_t q_rd,
  output logic           q_pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [1:0]     out_command,
  output logic [7:0]     out_out_byte,
  output logic           out_last,
  output logic [2:0]     out_outcome,
  output logic           out_quiescent
);
  import arc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE,
    S_PROG_RD,
    S_PROG_WR
  } state_t;

  function automatic logic [2:0] classify_code(input logic [2:0] code);
    logic [2:0] oc;
    if (code <= CODE_NOT_ACTIVE) begin
      oc = OC_ACTED;
    end else if (code == CODE_RETRY) begin
      oc = OC_BUSY;
    end else begin
      oc = OC_FAULTED;
    end
    return oc;
  endfunction

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_m1;
  logic             wanted_r, wanted_nxt;
  logic             ready_r, ready_nxt;
  logic             running_r, running_nxt;
  logic             fault_r, fault_nxt;
  logic             ok_r, ok_nxt;
  logic             stale_r, stale_nxt;
  logic             differs_r, differs_nxt;
  logic [7:0]       links_r, links_nxt;
  logic [1:0]       pend_r, pend_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_command_r, out_command_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [2:0]       out_outcome_r, out_outcome_nxt;
  logic             out_quiescent_r, out_quiescent_nxt;

  logic             slot_free;
  logic             emit;
  logic [1:0]       emit_cmd;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [2:0]       emit_oc;
  logic [2:0]       res_oc;

  logic             stg_we, stg_re, held_we, held_re;
  logic [IDX_W-1:0] stg_waddr, held_waddr, held_raddr;
  logic [7:0]       stg_rdata, held_rdata;

  arc_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_staged (
    .clk     (clk),
    .wr_en   (stg_we),
    .wr_addr (stg_waddr),
    .wr_data (q_rd.entry.data),
    .rd_en   (stg_re),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (stg_rdata)
  );

  arc_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_held (
    .clk     (clk),
    .wr_en   (held_we),
    .wr_addr (held_waddr),
    .wr_data (stg_rdata),
    .rd_en   (held_re),
    .rd_addr (held_raddr),
    .rd_data (held_rdata)
  );

  assign slot_free  = !out_valid_r || !out_stall;
  assign cnt_m1     = cnt_r - CNT_W'(1);
  assign stg_waddr  = q_rd.entry.idx;
  assign held_waddr = cnt_m1[IDX_W-1:0];
  assign held_raddr = cnt_r[IDX_W-1:0];
  assign res_oc     = classify_code(q_rd.entry.code);

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    wanted_nxt        = wanted_r;
    ready_nxt         = ready_r;
    running_nxt       = running_r;
    fault_nxt         = fault_r;
    ok_nxt            = ok_r;
    stale_nxt         = stale_r;
    differs_nxt       = differs_r;
    links_nxt         = links_r;
    pend_nxt          = pend_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_command_nxt   = out_command_r;
    out_byte_nxt      = out_byte_r;
    out_last_nxt      = out_last_r;
    out_outcome_nxt   = out_outcome_r;
    out_quiescent_nxt = out_quiescent_r;
    q_pop             = 1'b0;
    stg_we            = 1'b0;
    stg_re            = 1'b0;
    held_we           = 1'b0;
    held_re           = 1'b0;
    emit              = 1'b0;
    emit_cmd          = CMD_NONE;
    emit_byte         = 8'd0;
    emit_last         = 1'b1;
    emit_oc           = OC_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (q_rd.valid && slot_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          unique case (q_rd.entry.op)
            OP_BYTE:     stg_we = 1'b1;
            OP_COMMIT: begin
              stg_we      = 1'b1;
              emit        = 1'b0;
              cnt_nxt     = '0;
              differs_nxt = 1'b0;
              state_nxt   = S_SWEEP;
            end
            OP_WANT_ON:  wanted_nxt = 1'b1;
            OP_WANT_OFF: wanted_nxt = 1'b0;
            OP_READY:    ready_nxt = 1'b1;
            OP_RESET: begin
              ready_nxt   = 1'b0;
              running_nxt = 1'b0;
              fault_nxt   = 1'b0;
              pend_nxt    = CMD_NONE;
              if (ok_r) begin
                stale_nxt = 1'b1;
              end
            end
            OP_LINKS:    links_nxt = q_rd.entry.links;
            OP_ENDED:    running_nxt = 1'b0;
            OP_PROCESS: begin
              priority if (pend_r != CMD_NONE) begin
                emit_oc = OC_NONE;
              end else if (!ready_r) begin
                emit_oc = OC_RECONCILED;
              end else if (running_r && (!wanted_r || links_r != 8'd0 || stale_r)) begin
                pend_nxt = CMD_STOP;
                emit_cmd = CMD_STOP;
              end else if (fault_r) begin
                emit_oc = OC_FAULTED;
              end else if (!running_r && stale_r && ok_r) begin
                pend_nxt  = CMD_PROG;
                emit      = 1'b0;
                cnt_nxt   = '0;
                state_nxt = S_PROG_RD;
              end else if (!running_r && wanted_r && links_r == 8'd0 && ok_r &&
                           q_rd.entry.permit) begin
                pend_nxt = CMD_START;
                emit_cmd = CMD_START;
              end else begin
                emit_oc = OC_RECONCILED;
              end
            end
            OP_RESULT: begin
              if (pend_r != CMD_NONE) begin
                emit_oc  = res_oc;
                pend_nxt = CMD_NONE;
                if (res_oc == OC_ACTED) begin
                  priority if (pend_r == CMD_STOP) begin
                    running_nxt = 1'b0;
                  end else if (pend_r == CMD_PROG) begin
                    stale_nxt = 1'b0;
                  end else begin
                    running_nxt = 1'b1;
                  end
                end else if (res_oc == OC_FAULTED) begin
                  fault_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SWEEP: begin
        // Read entry cnt of both RAMs while copying entry cnt-1 into the held RAM.
        if (cnt_r != CNT_END) begin
          stg_re  = 1'b1;
          held_re = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (cnt_r != '0) begin
          held_we     = 1'b1;
          differs_nxt = differs_r | (stg_rdata != held_rdata);
        end
        if (cnt_r == CNT_END) begin
          state_nxt = S_DONE;
          if (!ok_r || differs_nxt) begin
            ok_nxt    = 1'b1;
            stale_nxt = 1'b1;
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_PROG_RD: begin
        held_re   = 1'b1;
        state_nxt = S_PROG_WR;
      end

      S_PROG_WR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_cmd  = CMD_PROG;
          emit_byte = held_rdata;
          emit_last = (cnt_r == CNT_LAST);
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = (cnt_r == CNT_LAST) ? S_IDLE : S_PROG_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_command_nxt   = emit_cmd;
      out_byte_nxt      = emit_byte;
      out_last_nxt      = emit_last;
      out_outcome_nxt   = emit_oc;
      out_quiescent_nxt = !running_nxt && !wanted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wanted_r    <= 1'b0;
      ready_r     <= 1'b0;
      running_r   <= 1'b0;
      fault_r     <= 1'b0;
      ok_r        <= 1'b0;
      stale_r     <= 1'b0;
      differs_r   <= 1'b0;
      links_r     <= 8'd0;
      pend_r      <= CMD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wanted_r    <= wanted_nxt;
      ready_r     <= ready_nxt;
      running_r   <= running_nxt;
      fault_r     <= fault_nxt;
      ok_r        <= ok_nxt;
      stale_r     <= stale_nxt;
      differs_r   <= differs_nxt;
      links_r     <= links_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_command_r   <= out_command_nxt;
    out_byte_r      <= out_byte_nxt;
    out_last_r      <= out_last_nxt;
    out_outcome_r   <= out_outcome_nxt;
    out_quiescent_r <= out_quiescent_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_command   = out_command_r;
  assign out_out_byte  = out_byte_r;
  assign out_last      = out_last_r;
  assign out_outcome   = out_outcome_r;
  assign out_quiescent = out_quiescent_r;

endmodule

// ----- rtl/core/advertising_reconcile_controller.sv -----
// Top level of the advertising reconcile controller.
// Depends on arc_pkg, arc_front, arc_queue, arc_back and arc_ram.
//
// This block tracks the advertising state that the application wants against the state
// that the radio stack has applied, and on each process event issues at most one command
// to move the stack toward the wanted state. Every input item gives exactly one result
// item, except a process event that picks the program command: that one streams the held
// payload out as one result per payload byte, with last set on the final byte. Items are
// classified on entry and wait in a two-item queue, so the input side keeps accepting,
// until the queue is full, while the result register is stalled. For the item that
// completes the payload, the staged and held payloads are compared and copied one byte
// per cycle through the payload RAMs. A program command streams each byte by first
// reading it from the held payload RAM, which has a registered read, and then loading it
// into the result register once that register is free. A stack result event classifies
// the reply of the last command: codes ok, already and not active count as acted, retry
// as busy, anything else as faulted.
module advertising_reconcile_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_mode,
  input  logic [7:0] in_payload_byte,
  input  logic [4:0] in_byte_index,
  input  logic [7:0] in_link_count,
  input  logic       in_start_permit,
  input  logic [2:0] in_stack_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_command,
  output logic [7:0] out_out_byte,
  output logic       out_last,
  output logic [2:0] out_outcome,
  output logic       out_quiescent
);
  import arc_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Front end: decodes the event mode and the byte index into one operation.
  arc_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_payload_byte (in_payload_byte),
    .in_byte_index   (in_byte_index),
    .in_link_count   (in_link_count),
    .in_start_permit (in_start_permit),
    .in_stack_code   (in_stack_code),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  // The queue lets the front end keep taking items, until it is full, while the back end waits.
  arc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_rd   (q_rd),
    .q_full (q_full)
  );

  // Back end: owns all reconcile state and drives the result register.
  arc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd          (q_rd),
    .q_pop         (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_command   (out_command),
    .out_out_byte  (out_out_byte),
    .out_last      (out_last),
    .out_outcome   (out_outcome),
    .out_quiescent (out_quiescent)
  );

  // The back end only takes an operation that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("operation taken from an empty queue");

  // Only a program stream produces results that are not the last of their item.
  a_stream_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_command == CMD_PROG && out_outcome == OC_NONE))
    else $error("non-final result outside a program stream");

  // A result that reports an outcome never issues a command and always ends its item.
  a_outcome_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != OC_NONE) |-> (out_command == CMD_NONE && out_last))
    else $error("outcome reported together with a command");

endmodule
